>>> rtl/core/aes_pkg.sv
// Package: shared types, constants and byte functions for the key expansion block.
`default_nettype none
package aes_pkg;
   localparam int unsigned NumRounds = 11;
   localparam logic [3:0] LastRound = 4'd10;
   localparam logic [3:0] StageAddKey = 4'd0;
   localparam logic [3:0] StageSub = 4'd1;
   localparam logic [3:0] StageShift = 4'd2;
   localparam logic [3:0] StageMix = 4'd3;
   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow = 1'b1;
   localparam logic KindKey = 1'b0;
   localparam logic KindState = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_KEY   = 5'b00010,
      ST_STATE = 5'b00100,
      ST_OUT   = 5'b01000,
      ST_LAST  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;     // latch block, load key into schedule
      logic key_step; // advance to next round key
      logic st_step;  // advance state pipeline one stage
   } cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/aes_ctrl.sv
// Controller: sequences round keys and state stages onto the result channel.
`default_nettype none
module aes_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic                 out_kind,
   output logic [3:0]           out_step,
   output logic                 out_last,
   output aes_pkg::cmd_type     cmd
);
   aes_pkg::state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic take;

   assign take = out_valid && out_ready;
   assign in_ready = (state_ff == aes_pkg::ST_IDLE);
   assign out_valid = (state_ff == aes_pkg::ST_KEY) || (state_ff == aes_pkg::ST_STATE);
   assign out_kind = (state_ff == aes_pkg::ST_STATE) ? aes_pkg::KindState : aes_pkg::KindKey;
   assign out_step = step_ff;
   assign out_last = (state_ff == aes_pkg::ST_STATE) && (step_ff == aes_pkg::StageMix);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = aes_pkg::ST_KEY;
               step_in = 4'd0;
            end
         end
         aes_pkg::ST_KEY: begin
            if (take) begin
               if (step_ff == aes_pkg::LastRound) begin
                  state_in = aes_pkg::ST_STATE;
                  step_in = aes_pkg::StageAddKey;
               end else begin
                  cmd.key_step = 1'b1;
                  step_in = step_ff + 4'd1;
               end
            end
         end
         aes_pkg::ST_STATE: begin
            if (take) begin
               if (out_last) begin
                  state_in = aes_pkg::ST_IDLE;
               end else begin
                  cmd.st_step = 1'b1;
                  step_in = step_ff + 4'd1;
               end
            end
         end
         default: state_in = aes_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aes_pkg::ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   a_one: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_idle: assert property (@(posedge clock) disable iff (reset) in_ready |-> !out_valid)
      else $error("busy overlap");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (take && out_last) |=> in_ready) else $error("no return to idle");
endmodule
`default_nettype wire

>>> rtl/core/aes_dp.sv
// Datapath: key schedule one round per word and the staged first round.
`default_nettype none
module aes_dp (
   input  wire logic            clock,
   input  wire aes_pkg::cmd_type cmd,
   input  wire logic [63:0]     key_high,
   input  wire logic [63:0]     key_low,
   input  wire logic [127:0]    block,
   input  wire logic [3:0]      step,
   input  wire logic            is_state,
   output logic [127:0]         value
);
   logic [127:0] rk_ff, rk_in, st_ff, st_in;
   logic [31:0] rot, sw;
   logic [7:0] b [16];
   logic [7:0] m [16];

   assign rot = {rk_ff[23:0], rk_ff[31:24]};
   always_comb begin
      for (int i = 0; i < 4; i++) sw[8*i +: 8] = aes_pkg::sbox(rot[8*i +: 8]);
      sw[31:24] = sw[31:24] ^ aes_pkg::rcon(step + 4'd1);
      rk_in[127:96] = rk_ff[127:96] ^ sw;
      rk_in[95:64] = rk_ff[95:64] ^ rk_in[127:96];
      rk_in[63:32] = rk_ff[63:32] ^ rk_in[95:64];
      rk_in[31:0] = rk_ff[31:0] ^ rk_in[63:32];
   end

   // byte 0 is the top byte
   always_comb begin
      for (int i = 0; i < 16; i++) b[i] = st_ff[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            m[4*c+r] = aes_pkg::xtime(b[4*c+r]) ^ aes_pkg::xtime(b[4*c+((r+1)%4)])
               ^ b[4*c+((r+1)%4)] ^ b[4*c+((r+2)%4)] ^ b[4*c+((r+3)%4)];
      st_in = st_ff;
      case (step)
         aes_pkg::StageAddKey:
            for (int i = 0; i < 16; i++) st_in[127-8*i -: 8] = aes_pkg::sbox(b[i]);
         aes_pkg::StageSub:
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  st_in[127-8*(4*c+r) -: 8] = b[4*((c+r)%4)+r];
         default:
            for (int i = 0; i < 16; i++) st_in[127-8*i -: 8] = m[i];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rk_ff <= {key_high, key_low};
         st_ff <= block ^ {key_high, key_low};
      end else begin
         if (cmd.key_step) rk_ff <= rk_in;
         if (cmd.st_step) st_ff <= st_in;
      end
   end
   assign value = is_state ? st_ff : rk_ff;
endmodule
`default_nettype wire

>>> rtl/core/aes128_key_expand_first_round.sv
// Top level: AES-128 key expansion and first round, stream in and stream out.
// The first result word is registered in the cycle after a block is accepted; 15 results per block.
// A new block is not taken until every result word of the last one has been taken.
// The single round-key register steps once per taken key word, but not after the last round key.
// Reset (synchronous, active high) clears the controller and both key registers.
// After reset the block is idle and ready for a word.
`default_nettype none
module aes128_key_expand_first_round (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // block_high[63:0], block_low[127:64]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,  // step_index[3:0], value_high[67:4], value_low[131:68]
   output logic              rsp_tuser,  // kind
   output logic              rsp_tlast,  // last
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);
   // req_tdata: block_high in [63:0], block_low in [127:64]
   logic [63:0] key_high_ff, key_low_ff;
   aes_pkg::cmd_type cmd;
   logic kind;
   logic [3:0] step;
   logic [127:0] value;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            aes_pkg::CsrKeyHigh: key_high_ff <= csr_wdata;
            aes_pkg::CsrKeyLow: key_low_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   aes_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_kind(kind),
      .out_step(step), .out_last(rsp_tlast), .cmd(cmd));

   aes_dp u_dp (
      .clock(clock), .cmd(cmd), .key_high(key_high_ff), .key_low(key_low_ff),
      .block({req_tdata[63:0], req_tdata[127:64]}), .step(step),
      .is_state(kind), .value(value));

   assign rsp_tuser = kind;
   assign rsp_tdata = {4'd0, value[63:0], value[127:64], step};
endmodule
`default_nettype wire

>>> dv/tb_aes128_key_expand_first_round.sv
// Testbench: AES-128 key schedule and first round, checked against an in-bench predictor.
`timescale 1ns / 100ps
module tb_aes128_key_expand_first_round;

   localparam int CycleLimit = 1500000;
   localparam int SettleCycles = 20;

   // Forward S-box, used by the predictor only.
   localparam logic [7:0] SubTable [256] = '{
   8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
   8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
   8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
   8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
   8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
   8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
   8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
   8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
   8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
   8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
   8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
   8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
   8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
   8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
   8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
   8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] RoundConst [11] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   // one expected result word
   typedef struct {
      logic        kind;
      logic [3:0]  step;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        last;
   } aes_word_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;   // block_high[63:0], block_low[127:64]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;        // step_index[3:0], value_high[67:4], value_low[131:68]
   logic          rsp_tuser;        // kind
   logic          rsp_tlast;        // last
   logic          csr_we = 1'b0;
   logic [0:0]    csr_index = aes_pkg::CsrKeyHigh;
   logic [63:0]   csr_wdata = '0;

   aes_word_type  expected_words [$];
   logic [63:0]   key_hi_shadow = '0;
   logic [63:0]   key_lo_shadow = '0;
   int            mismatches = 0;
   int            cycles = 0;
   int            rx_hold_req = 0;  // long receiver hold-off, picked up by receiver
   bit            no_idle = 1'b0;   // stretch with no idling on either side

   aes128_key_expand_first_round dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("aes128_key_expand_first_round verification failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int p;
      p = $urandom_range(99);
      if (no_idle) return 0;
      if (p < 60) return 0;
      if (p < 85) return $urandom_range(3, 1);
      if (p < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] v);
      return {SubTable[v[31:24]], SubTable[v[23:16]], SubTable[v[15:8]], SubTable[v[7:0]]};
   endfunction

   function automatic logic [127:0] bytes_to_vec(input logic [7:0] b [16]);
      logic [127:0] v;
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = b[i];
      return v;
   endfunction

   // Expected 15 words for one block: 11 round keys, then the four round stages.
   function automatic void predict_round_words(input logic [63:0] blk_hi,
                                               input logic [63:0] blk_lo);
      logic [31:0]  w [44];
      logic [31:0]  t;
      logic [7:0]   s [16];
      logic [7:0]   n [16];
      logic [127:0] v;
      aes_word_type e;
      w[0] = key_hi_shadow[63:32]; w[1] = key_hi_shadow[31:0];
      w[2] = key_lo_shadow[63:32]; w[3] = key_lo_shadow[31:0];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) t = sbox_word({t[23:0], t[31:24]}) ^ {RoundConst[i/4], 24'h0};
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) begin
         e.kind = aes_pkg::KindKey; e.step = 4'(r); e.last = 1'b0;
         e.hi = {w[4*r], w[4*r+1]}; e.lo = {w[4*r+2], w[4*r+3]};
         expected_words.push_back(e);
      end
      v = {blk_hi, blk_lo} ^ {w[0], w[1], w[2], w[3]};
      for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
      for (int stage = 0; stage < 4; stage++) begin
         case (4'(stage))
            aes_pkg::StageSub: for (int i = 0; i < 16; i++) s[i] = SubTable[s[i]];
            aes_pkg::StageShift: begin
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++) n[4*c+r] = s[4*((c+r)%4)+r];
               s = n;
            end
            aes_pkg::StageMix: begin
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++)
                     n[4*c+r] = gf_double(s[4*c+r]) ^ gf_double(s[4*c+(r+1)%4])
                              ^ s[4*c+(r+1)%4] ^ s[4*c+(r+2)%4] ^ s[4*c+(r+3)%4];
               s = n;
            end
            default: ;
         endcase
         v = bytes_to_vec(s);
         e.kind = aes_pkg::KindState; e.step = 4'(stage);
         e.last = (4'(stage) == aes_pkg::StageMix);
         e.hi = v[127:64]; e.lo = v[63:0];
         expected_words.push_back(e);
      end
   endfunction

   // Receiver: random ready with occasional long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_req > 0) begin
            stall_left = rx_hold_req;
            rx_hold_req = 0;
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (no_idle || $urandom_range(99) < 65) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b0;
            stall_left = idle_gap();
         end
      end
   end

   // Checker: each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      aes_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: %h", rsp_tdata);
         end else begin
            e = expected_words.pop_front();
            if (rsp_tuser !== e.kind || rsp_tdata[3:0] !== e.step
                || rsp_tdata[67:4] !== e.hi || rsp_tdata[131:68] !== e.lo
                || rsp_tlast !== e.last || rsp_tdata[135:132] !== 4'h0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp kind %0d step %0d %h_%h last %0d, got kind %0d step %0d %h_%h last %0d",
                     e.kind, e.step, e.hi, e.lo, e.last, rsp_tuser, rsp_tdata[3:0],
                     rsp_tdata[67:4], rsp_tdata[131:68], rsp_tlast);
            end
         end
      end
   end

   // One block word; valid stays up into the next word when there is no gap.
   task automatic send_block(input logic [63:0] blk_hi, input logic [63:0] blk_lo);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {blk_lo, blk_hi};
      do @(posedge clock); while (!req_tready);
      predict_round_words(blk_hi, blk_lo);
   endtask

   // Wait out every expected word plus the block's own latency.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
      drain();
      @(negedge clock);
      csr_we = 1'b1; csr_index = aes_pkg::CsrKeyHigh; csr_wdata = hi;
      @(negedge clock);
      csr_index = aes_pkg::CsrKeyLow; csr_wdata = lo;
      @(negedge clock);
      csr_we = 1'b0;
      key_hi_shadow = hi;
      key_lo_shadow = lo;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // zero key after reset, then the standard test key, extremes of block and key
   task automatic test_directed();
      send_block('0, '0);
      send_block('1, '1);
      write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8080808080808080, 64'h0101010101010101);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      write_key('1, '1);
      send_block('0, '1);
      send_block('1, '0);
      write_key('0, '1);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      write_key('1, '0);
      send_block(rand64(), rand64());
      write_key(64'h8000000000000000, 64'h0000000000000001);
      send_block(rand64(), rand64());
   endtask

   // receiver holds off long while the sender keeps offering words
   task automatic test_backpressure();
      no_idle = 1'b1;
      rx_hold_req = 300;
      repeat (6) send_block(rand64(), rand64());
      no_idle = 1'b0;
      drain();  // sender pauses for every expected word
   endtask

   // no idling on either side for a stretch of back-to-back blocks
   task automatic test_streaming();
      no_idle = 1'b1;
      repeat (20) send_block(rand64(), rand64());
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      for (int i = 0; i < 260; i++) begin
         if (i % 50 == 49) write_key(rand64(), rand64());
         send_block(rand64(), rand64());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_streaming();
      test_random();
      drain();
      if (mismatches == 0 && expected_words.size() == 0)
         $display("aes128_key_expand_first_round verification clean");
      else
         $display("aes128_key_expand_first_round verification failed");
      $finish;
   end
endmodule

>>> aes128_key_expand_first_round.f
rtl/core/aes_pkg.sv
rtl/core/aes_ctrl.sv
rtl/core/aes_dp.sv
rtl/core/aes128_key_expand_first_round.sv
dv/tb_aes128_key_expand_first_round.sv
